FILE: rtl/core/mkp_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared constants, types and lookup functions of the keypad scanner core.
// ----------------------------------------------------------------------------
package mkp_pkg;

    localparam int BUF_DEPTH = 5;
    localparam int BUF_IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef logic [BUF_IDX_W-1:0] buf_idx_t;

    localparam logic [3:0]  SENSE_IDLE   = 4'hF;
    localparam logic [15:0] SETTLE_RST   = 16'd4000;
    localparam logic [15:0] DEBOUNCE_RST = 16'd50000;

    // Result event codes.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SETTLE   = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [1:0] CFG_BEEP     = 2'd2;

    typedef struct packed {
        logic [15:0] settle;
        logic [15:0] debounce;
        logic        beep_en;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } store_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic       found;
        logic [7:0] code;
    } pop_res_t;

    function automatic logic [3:0] row_pattern(input logic [1:0] idx);
        logic [3:0] pat;
        case (idx)
            2'd0:    pat = 4'h7;
            2'd1:    pat = 4'hB;
            2'd2:    pat = 4'hD;
            default: pat = 4'hE;
        endcase
        return pat;
    endfunction

    function automatic buf_idx_t buf_next(input buf_idx_t idx);
        buf_idx_t nxt;
        if (idx == buf_idx_t'(BUF_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + buf_idx_t'(1);
        end
        return nxt;
    endfunction

    // ASCII of a key; a column pattern that is not a single low line maps to column 0.
    function automatic logic [7:0] key_ascii(input logic [1:0] row_idx,
                                             input logic [3:0] cols);
        logic [1:0] col;
        logic [1:0] map_row;
        logic [7:0] code;
        case (cols)
            4'h7:    col = 2'd0;
            4'hB:    col = 2'd1;
            4'hD:    col = 2'd2;
            4'hE:    col = 2'd3;
            default: col = 2'd0;
        endcase
        map_row = ~row_idx;
        case ({map_row, col})
            4'h0:    code = 8'h31;
            4'h1:    code = 8'h32;
            4'h2:    code = 8'h33;
            4'h3:    code = 8'h41;
            4'h4:    code = 8'h34;
            4'h5:    code = 8'h35;
            4'h6:    code = 8'h36;
            4'h7:    code = 8'h42;
            4'h8:    code = 8'h37;
            4'h9:    code = 8'h38;
            4'hA:    code = 8'h39;
            4'hB:    code = 8'h43;
            4'hC:    code = 8'h2A;
            4'hD:    code = 8'h30;
            4'hE:    code = 8'h23;
            default: code = 8'h44;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/core/matrix_keypad_scanner_with_key_buffer_core.sv
// Flow: a tick request passes through TICK and then DONE; a pop request waits
// in POP while the ring searches one slot a cycle, then passes through DONE.
// Handshake: one request in flight; the next is accepted once the result
// is handed to the output register.
// Reset: synchronous active-low aresetn clears scan state and key slots and
// returns the configuration registers to their reset values.
// ----------------------------------------------------------------------------
// Matrix keypad scanner with key buffer
// Top level: request sequencer, configuration registers and result register.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_with_key_buffer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] sense, [7:4] zero
    input  logic        s_tuser,   // [0] mode: 0 time tick, 1 pop
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] row_drive, [5:4] event_res, [6] key_found,
                                   // [14:7] key_code, [15] beep
);

    // The sequencer runs one request at a time. A tick request passes
    // through TICK, where the scanner advances its shared wait counter; a
    // pop request sits in POP while the ring searches slot by slot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TICK = 2'd1,
        ST_POP  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0]          sense_reg, sense_next;
    logic [1:0]          ev_reg, ev_next;
    logic                beep_reg, beep_next;
    logic                found_reg, found_next;
    logic [7:0]          code_reg, code_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;

    mkp_pkg::cfg_t       cfg_reg;
    mkp_pkg::store_req_t store;
    mkp_pkg::pop_res_t   pop_res;
    logic                accept;
    logic                pop_start;
    logic                tick_en;
    logic [3:0]          row_drive;
    logic [1:0]          scan_ev;
    logic                scan_beep;

    // Configuration writes are not gated; the user must issue them with the block idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle   <= mkp_pkg::SETTLE_RST;
            cfg_reg.debounce <= mkp_pkg::DEBOUNCE_RST;
            cfg_reg.beep_en  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mkp_pkg::CFG_SETTLE:   cfg_reg.settle   <= cfg_wdata;
                mkp_pkg::CFG_DEBOUNCE: cfg_reg.debounce <= cfg_wdata;
                mkp_pkg::CFG_BEEP:     cfg_reg.beep_en  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign pop_start = accept && s_tuser;
    assign tick_en   = (state_reg == ST_TICK);

    mkp_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (tick_en),
        .sense     (sense_reg),
        .cfg       (cfg_reg),
        .row_drive (row_drive),
        .store     (store),
        .ev        (scan_ev),
        .beep      (scan_beep)
    );

    mkp_ring u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .store     (store),
        .pop_start (pop_start),
        .pop_res   (pop_res)
    );

    // Results collect in holding registers and move to the output register
    // in DONE, once the output register is free or being drained. The row
    // pattern is read there, so it reflects the scan state after the request.
    always_comb begin
        state_next    = state_reg;
        sense_next    = sense_reg;
        ev_next       = ev_reg;
        beep_next     = beep_reg;
        found_next    = found_reg;
        code_next     = code_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sense_next = s_tdata[3:0];
                    state_next = s_tuser ? ST_POP : ST_TICK;
                end
            end
            ST_TICK: begin
                ev_next    = scan_ev;
                beep_next  = scan_beep;
                found_next = 1'b0;
                code_next  = 8'h00;
                state_next = ST_DONE;
            end
            ST_POP: begin
                if (pop_res.done) begin
                    ev_next    = mkp_pkg::EV_NONE;
                    beep_next  = 1'b0;
                    found_next = pop_res.found;
                    code_next  = pop_res.code;
                    state_next = ST_DONE;
                end
            end
            default: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {beep_reg, code_reg, found_reg, ev_reg, row_drive};
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sense_reg   <= sense_next;
        ev_reg      <= ev_next;
        beep_reg    <= beep_next;
        found_reg   <= found_next;
        code_reg    <= code_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // The ring searches only while the sequencer waits for a pop.
    a_pop_busy_in_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_res.busy |-> (state_reg == ST_POP))
        else $error("ring search active outside a pop request");

    // The scanner stores a key only during a tick cycle.
    a_store_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        store.valid |-> tick_en)
        else $error("key stored outside a tick request");

    // A result never reports both a scan event and a popped entry.
    a_event_xor_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[5:4] != mkp_pkg::EV_NONE) |-> !m_tdata[6])
        else $error("result carries both an event and a popped key");

    // A beep accompanies only a stored key press.
    a_beep_on_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15]) |-> (m_tdata[5:4] == mkp_pkg::EV_PRESS))
        else $error("beep without a key press");
`endif

endmodule

FILE: rtl/core/mkp_scan.sv
// ----------------------------------------------------------------------------
// Keypad row scanner
// Row, debounce and release sequencing around one shared tick counter.
// ----------------------------------------------------------------------------
module mkp_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick_en,
    input  logic [3:0]          sense,
    input  mkp_pkg::cfg_t       cfg,
    output logic [3:0]          row_drive,
    output mkp_pkg::store_req_t store,
    output logic [1:0]          ev,
    output logic                beep
);

    typedef enum logic [1:0] {
        PH_SETTLE   = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_RELEASE  = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  row_reg, row_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] limit;
    logic [16:0] cnt_inc;
    logic        done;

    // The one counter/compare unit, shared by every wait.
    assign limit   = (phase_reg == PH_DEBOUNCE) ? cfg.debounce : cfg.settle;
    assign cnt_inc = {1'b0, wait_reg} + 17'd1;
    assign done    = (cnt_inc >= {1'b0, limit});

    always_comb begin
        phase_next = phase_reg;
        row_next   = row_reg;
        wait_next  = wait_reg;
        store      = '0;
        ev         = mkp_pkg::EV_NONE;
        if (tick_en) begin
            wait_next = done ? 16'd0 : cnt_inc[15:0];
            case (phase_reg)
                PH_DEBOUNCE: begin
                    if (done) begin
                        if (sense == mkp_pkg::SENSE_IDLE) begin
                            row_next   = 2'd0;
                            phase_next = PH_SETTLE;
                        end else begin
                            store.valid = 1'b1;
                            store.code  = mkp_pkg::key_ascii(row_reg, sense);
                            ev          = mkp_pkg::EV_PRESS;
                            phase_next  = PH_RELEASE;
                        end
                    end
                end
                PH_RELEASE: begin
                    if (done && sense == mkp_pkg::SENSE_IDLE) begin
                        store.valid = 1'b1;
                        store.code  = 8'h00;
                        ev          = mkp_pkg::EV_RELEASE;
                        row_next    = 2'd0;
                        phase_next  = PH_SETTLE;
                    end
                end
                default: begin
                    phase_next = PH_SETTLE;
                    if (done) begin
                        if (sense != mkp_pkg::SENSE_IDLE) begin
                            phase_next = PH_DEBOUNCE;
                        end else begin
                            row_next = row_reg + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    assign beep      = store.valid && cfg.beep_en && (store.code != 8'h00);
    assign row_drive = mkp_pkg::row_pattern(row_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SETTLE;
            row_reg   <= 2'd0;
            wait_reg  <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

FILE: rtl/core/mkp_ring.sv
// ----------------------------------------------------------------------------
// Keypad key ring
// Overwriting ring of key slots with a one-slot-per-cycle pop search.
// ----------------------------------------------------------------------------
module mkp_ring (
    input  logic                aclk,
    input  logic                aresetn,
    input  mkp_pkg::store_req_t store,
    input  logic                pop_start,
    output mkp_pkg::pop_res_t   pop_res
);

    logic [mkp_pkg::BUF_DEPTH-1:0] valid_reg;
    logic [7:0]                    code_mem [mkp_pkg::BUF_DEPTH];
    logic [7:0]                    rd_code_reg;
    mkp_pkg::buf_idx_t             wp_reg;
    mkp_pkg::buf_idx_t             ptr_reg;
    mkp_pkg::buf_idx_t             cnt_reg;
    mkp_pkg::buf_idx_t             store_pos;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          found_reg;

    assign store_pos = mkp_pkg::buf_next(wp_reg);

    always_ff @(posedge aclk) begin
        if (store.valid) begin
            code_mem[store_pos] <= store.code;
        end
        rd_code_reg <= code_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            wp_reg    <= mkp_pkg::buf_idx_t'(mkp_pkg::BUF_DEPTH - 1);
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (store.valid) begin
                wp_reg               <= store_pos;
                valid_reg[store_pos] <= 1'b1;
            end
            if (pop_start) begin
                busy_reg <= 1'b1;
                ptr_reg  <= mkp_pkg::buf_next(wp_reg);
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (valid_reg[ptr_reg]) begin
                    valid_reg[ptr_reg] <= 1'b0;
                    found_reg          <= 1'b1;
                    done_reg           <= 1'b1;
                    busy_reg           <= 1'b0;
                end else if (cnt_reg == mkp_pkg::buf_idx_t'(mkp_pkg::BUF_DEPTH - 1)) begin
                    found_reg <= 1'b0;
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                end else begin
                    ptr_reg <= mkp_pkg::buf_next(ptr_reg);
                    cnt_reg <= cnt_reg + mkp_pkg::buf_idx_t'(1);
                end
            end
        end
    end

    assign pop_res.busy  = busy_reg;
    assign pop_res.done  = done_reg;
    assign pop_res.found = found_reg;
    assign pop_res.code  = found_reg ? rd_code_reg : 8'h00;

endmodule

FILE: bench/matrix_keypad_scanner_with_key_buffer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad scanner core testbench
// Drives tick and pop requests into the scanner core and compares every
// result word with a behavioral scanner in the bench or a typed table row.
// A short table of hand-picked requests comes first, then random key
// presses, bounces and pops under three back-pressure profiles.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_with_key_buffer_core_test;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SEGMENT_ITEMS = 100;
    localparam int SEGMENTS      = 6;
    localparam int DRAIN_CYCLES  = 10;

    // Register index that the core must ignore.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Row drive pattern of row i sits in bits [4*i +: 4].
    localparam logic [15:0]  ROW_PATTERNS = 16'hEDB7;
    // Key legend, map row 0 first; character k sits in bits [127-8*k -: 8].
    localparam logic [127:0] KEY_LEGEND   = "123A456B789C*0#D";

    // Scan phases of the behavioral model.
    typedef enum logic [1:0] {
        SCAN_ROW      = 2'd0,
        SCAN_DEBOUNCE = 2'd1,
        SCAN_RELEASE  = 2'd2
    } scan_phase_t;

    // One result word, laid out exactly as m_tdata.
    typedef struct packed {
        logic       beep;
        logic [7:0] code;
        logic       found;
        logic [1:0] ev;
        logic [3:0] row;
    } key_result_t;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        STEP_TICK = 2'd0,
        STEP_POP  = 2'd1,
        STEP_CFG  = 2'd2
    } step_kind_t;

    // For requests, value carries the sense lines; for register writes it is
    // the write data. A row with typed set carries its own expected result.
    typedef struct packed {
        step_kind_t  kind;
        logic [1:0]  reg_idx;
        logic [15:0] value;
        logic        typed;
        key_result_t want;
    } plan_row_t;

    // Quiet results: nothing stored, nothing popped, only the row drive.
    localparam key_result_t QUIET_R0 = '{1'b0, 8'h00, 1'b0, mkp_pkg::EV_NONE, 4'h7};
    localparam key_result_t QUIET_R1 = '{1'b0, 8'h00, 1'b0, mkp_pkg::EV_NONE, 4'hB};
    localparam key_result_t QUIET_R2 = '{1'b0, 8'h00, 1'b0, mkp_pkg::EV_NONE, 4'hD};
    localparam key_result_t QUIET_R3 = '{1'b0, 8'h00, 1'b0, mkp_pkg::EV_NONE, 4'hE};
    localparam key_result_t NO_TYPED = '0;

    localparam int PLAN_LEN = 39;

    // Directed table. It starts at the reset settings (long settle and
    // debounce), so the first requests only count time.
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // Pop of the empty buffer and a tick right after reset.
        '{STEP_POP,  '0,                    16'h0000, 1'b1, QUIET_R0},
        '{STEP_TICK, '0,                    16'h000F, 1'b1, QUIET_R0},
        // The settle register drops to the running count: the wait
        // must end on the very next tick.
        '{STEP_CFG,  mkp_pkg::CFG_SETTLE,   16'd1,    1'b0, NO_TYPED},
        '{STEP_CFG,  mkp_pkg::CFG_DEBOUNCE, 16'd1,    1'b0, NO_TYPED},
        '{STEP_CFG,  mkp_pkg::CFG_BEEP,     16'd1,    1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b1, QUIET_R1},
        // Press on row 1, confirmed after debounce, held with all lines
        // low, then released.
        '{STEP_TICK, '0,                    16'h000E, 1'b1, QUIET_R1},
        '{STEP_TICK, '0,                    16'h000E, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h0000, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b0, NO_TYPED},
        // Pop the key, pop the release code, then find the buffer empty.
        '{STEP_POP,  '0,                    16'h000F, 1'b0, NO_TYPED},
        '{STEP_POP,  '0,                    16'h0005, 1'b0, NO_TYPED},
        '{STEP_POP,  '0,                    16'h000A, 1'b1, QUIET_R0},
        // Bounce: the debounce sample sees all lines high again.
        '{STEP_TICK, '0,                    16'h0003, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b0, NO_TYPED},
        // Several lines low at once: column 0 wins.
        '{STEP_TICK, '0,                    16'h0000, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h0000, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b0, NO_TYPED},
        // Beep off; a full idle scan wraps from row 3 back to row 0.
        '{STEP_CFG,  mkp_pkg::CFG_BEEP,     16'd0,    1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b1, QUIET_R1},
        '{STEP_TICK, '0,                    16'h000F, 1'b1, QUIET_R2},
        '{STEP_TICK, '0,                    16'h000F, 1'b1, QUIET_R3},
        '{STEP_TICK, '0,                    16'h000F, 1'b1, QUIET_R0},
        '{STEP_TICK, '0,                    16'h000D, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000D, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b0, NO_TYPED},
        // Zero waits act as one tick; a write to the unused index is dropped.
        '{STEP_CFG,  mkp_pkg::CFG_SETTLE,   16'd0,    1'b0, NO_TYPED},
        '{STEP_CFG,  mkp_pkg::CFG_DEBOUNCE, 16'd0,    1'b0, NO_TYPED},
        '{STEP_CFG,  CFG_UNUSED,            16'hFFFF, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000B, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000B, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b0, NO_TYPED},
        // Longest waits; the ring has wrapped, so pops see overwritten slots.
        '{STEP_CFG,  mkp_pkg::CFG_SETTLE,   16'hFFFF, 1'b0, NO_TYPED},
        '{STEP_CFG,  mkp_pkg::CFG_DEBOUNCE, 16'hFFFF, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h0000, 1'b0, NO_TYPED},
        '{STEP_POP,  '0,                    16'h0000, 1'b0, NO_TYPED},
        '{STEP_POP,  '0,                    16'h000F, 1'b0, NO_TYPED},
        '{STEP_POP,  '0,                    16'h0000, 1'b0, NO_TYPED},
        '{STEP_TICK, '0,                    16'h000F, 1'b0, NO_TYPED}
    };

    // ------------------------------------------------------------------
    // Block under test and its stimulus signals.
    // ------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    matrix_keypad_scanner_with_key_buffer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Behavioral scanner: configuration, scan state and key ring.
    // ------------------------------------------------------------------
    logic [15:0]  cfg_settle;
    logic [15:0]  cfg_debounce;
    logic         cfg_beep;

    scan_phase_t  scan_st;
    logic [1:0]   row_sel;
    logic [15:0]  tick_cnt;
    logic [7:0]   held_code;
    logic         slot_full [mkp_pkg::BUF_DEPTH];
    logic [7:0]   slot_code [mkp_pkg::BUF_DEPTH];
    int           wr_pos;

    // Results still owed by the core, oldest first.
    key_result_t  pending_results [$];

    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           send_gap_pct   = 0;
    int           accept_stall_pct = 0;

    // A key pressed on the virtual keypad: the row index that must be driven
    // for the press to show, the column pattern it pulls low, and how many
    // more ticks it stays down.
    logic [1:0]   finger_row   = '0;
    logic [3:0]   finger_cols  = 4'hF;
    int           finger_ticks = 0;

    task automatic reset_model();
        cfg_settle   = mkp_pkg::SETTLE_RST;
        cfg_debounce = mkp_pkg::DEBOUNCE_RST;
        cfg_beep     = 1'b0;
        scan_st      = SCAN_ROW;
        row_sel      = '0;
        tick_cnt     = '0;
        held_code    = '0;
        for (int i = 0; i < mkp_pkg::BUF_DEPTH; i++) begin
            slot_full[i] = 1'b0;
            slot_code[i] = '0;
        end
        wr_pos = mkp_pkg::BUF_DEPTH - 1;
    endtask

    // Counts one tick of a wait. A limit of zero behaves like one, and a
    // limit lowered below the running count ends the wait at once.
    function automatic logic wait_elapsed(input logic [15:0] limit);
        int unsigned nxt;
        nxt = int'(tick_cnt) + 1;
        if (nxt >= int'(limit)) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = nxt[15:0];
        return 1'b0;
    endfunction

    // Writes a code into the ring after the last written slot, dropping the
    // oldest entry once the ring is full. Returns the beep request.
    function automatic logic push_key(input logic [7:0] code);
        wr_pos = (wr_pos + 1) % mkp_pkg::BUF_DEPTH;
        slot_full[wr_pos] = 1'b1;
        slot_code[wr_pos] = code;
        return cfg_beep && (code != 8'h00);
    endfunction

    // ASCII of the key under the driven row; anything but a single low
    // column line falls back to column 0.
    function automatic logic [7:0] legend_char(input logic [1:0] row,
                                               input logic [3:0] cols);
        int col;
        int k;
        col = 0;
        for (int i = 0; i < 4; i++) begin
            if (cols == ROW_PATTERNS[4*i +: 4]) begin
                col = i;
            end
        end
        k = (3 - int'(row)) * 4 + col;
        return KEY_LEGEND[127 - 8*k -: 8];
    endfunction

    // Advances the behavioral scanner by one request and returns the result
    // word the core has to produce for it.
    function automatic key_result_t predict_keypad_result(input logic mode,
                                                          input logic [3:0] sense);
        key_result_t r;
        int slot;
        r = '0;
        r.ev = mkp_pkg::EV_NONE;
        if (mode) begin
            // Pop: search from the slot after the write position, take the
            // first filled one and clear it. Time does not advance.
            slot = wr_pos;
            for (int n = 0; n < mkp_pkg::BUF_DEPTH; n++) begin
                slot = (slot + 1) % mkp_pkg::BUF_DEPTH;
                if (!r.found && slot_full[slot]) begin
                    r.found = 1'b1;
                    r.code  = slot_code[slot];
                    slot_full[slot] = 1'b0;
                    slot_code[slot] = '0;
                end
            end
        end else begin
            case (scan_st)
                SCAN_DEBOUNCE: begin
                    if (wait_elapsed(cfg_debounce)) begin
                        if (sense == mkp_pkg::SENSE_IDLE) begin
                            // Bounce: start over at the first row.
                            row_sel = '0;
                            scan_st = SCAN_ROW;
                        end else begin
                            held_code = legend_char(row_sel, sense);
                            r.beep    = push_key(held_code);
                            r.ev      = mkp_pkg::EV_PRESS;
                            scan_st   = SCAN_RELEASE;
                        end
                    end
                end
                SCAN_RELEASE: begin
                    // The held row stays driven; one release poll per settle.
                    if (wait_elapsed(cfg_settle) && sense == mkp_pkg::SENSE_IDLE) begin
                        held_code = '0;
                        r.beep    = push_key(8'h00);
                        r.ev      = mkp_pkg::EV_RELEASE;
                        row_sel   = '0;
                        scan_st   = SCAN_ROW;
                    end
                end
                default: begin
                    scan_st = SCAN_ROW;
                    if (wait_elapsed(cfg_settle)) begin
                        if (sense != mkp_pkg::SENSE_IDLE) begin
                            scan_st = SCAN_DEBOUNCE;
                        end else begin
                            row_sel = row_sel + 2'd1;
                        end
                    end
                end
            endcase
        end
        r.row = ROW_PATTERNS[4*row_sel +: 4];
        return r;
    endfunction

    // Column lines as a keypad would show them: a pressed key pulls its
    // column low only while its own row is driven. Now and then the lines
    // carry plain noise, which also produces bounces.
    function automatic logic [3:0] keypad_sense();
        logic [3:0] lines;
        if ($urandom_range(99) < 8) begin
            return 4'($urandom_range(15));
        end
        if (finger_ticks == 0 && $urandom_range(99) < 15) begin
            finger_row = 2'($urandom_range(3));
            if ($urandom_range(99) < 80) begin
                finger_cols = ROW_PATTERNS[4*$urandom_range(3) +: 4];
            end else begin
                finger_cols = 4'($urandom_range(14));
            end
            finger_ticks = $urandom_range(40, 1);
        end
        lines = mkp_pkg::SENSE_IDLE;
        if (finger_ticks > 0) begin
            finger_ticks--;
            if (row_sel == finger_row) begin
                lines = finger_cols;
            end
        end
        return lines;
    endfunction

    // Offers one request, holds it until the core takes it, then records
    // the expected result: the typed one if given, else the predicted one.
    task automatic send_request(input logic mode, input logic [3:0] sense,
                                input logic typed, input key_result_t want);
        key_result_t predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'h0, sense};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = predict_keypad_result(mode, sense);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Register writes happen only with the core idle: the sender stops and
    // every owed result is collected before the write.
    task automatic cfg_write(input logic [1:0] addr, input logic [15:0] data);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            mkp_pkg::CFG_SETTLE:   cfg_settle   = data;
            mkp_pkg::CFG_DEBOUNCE: cfg_debounce = data;
            mkp_pkg::CFG_BEEP:     cfg_beep     = data[0];
            default:               ;
        endcase
    endtask

    // Wait setting for a random segment: mostly short, so that keys get
    // confirmed, with zero, the maximum and middle values mixed in.
    function automatic logic [15:0] pick_wait();
        int roll;
        roll = $urandom_range(19);
        if (roll == 0) begin
            return 16'd0;
        end else if (roll == 1) begin
            return 16'hFFFF;
        end else if (roll < 4) begin
            return 16'($urandom_range(40, 6));
        end
        return 16'($urandom_range(4, 1));
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order compare.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        key_result_t want;
        key_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request owed, expected none, actual 0x%04h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("row_drive", want.row,   got.row);
                check_field("event_res", want.ev,    got.ev);
                check_field("key_found", want.found, got.found);
                check_field("key_code",  want.code,  got.code);
                check_field("beep",      want.beep,  got.beep);
            end
        end
        m_tready <= ($urandom_range(99) >= accept_stall_pct);
    end

    // Hard stop in case the core hangs on either handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[matrix_keypad_scanner_with_key_buffer_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random segments under three
    // back-pressure profiles.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic       mode;
        logic [3:0] sense;
        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender gaps 33 %, receiver stalls 73 % for the directed part and
        // the first random profile.
        send_gap_pct     = 33;
        accept_stall_pct = 73;
        for (int k = 0; k < PLAN_LEN; k++) begin
            if (PLAN[k].kind == STEP_CFG) begin
                cfg_write(PLAN[k].reg_idx, PLAN[k].value);
            end else begin
                send_request(PLAN[k].kind == STEP_POP, PLAN[k].value[3:0],
                             PLAN[k].typed, PLAN[k].want);
            end
        end

        for (int profile = 0; profile < 3; profile++) begin
            if (profile == 1) begin
                send_gap_pct     = 73;
                accept_stall_pct = 33;
            end else if (profile == 2) begin
                send_gap_pct     = 0;
                accept_stall_pct = 0;
            end
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                // Each segment runs on fresh settings; the writes drain the
                // core first, which also exercises a full pause of the sender.
                cfg_write(mkp_pkg::CFG_SETTLE,   pick_wait());
                cfg_write(mkp_pkg::CFG_DEBOUNCE, pick_wait());
                cfg_write(mkp_pkg::CFG_BEEP,     16'($urandom_range(1)));
                for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                    mode = ($urandom_range(99) < 20);
                    if (mode) begin
                        sense = 4'($urandom_range(15));
                    end else begin
                        sense = keypad_sense();
                    end
                    send_request(mode, sense, 1'b0, NO_TYPED);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[matrix_keypad_scanner_with_key_buffer_core] OK");
        end else begin
            $display("[matrix_keypad_scanner_with_key_buffer_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mkp_pkg.sv
rtl/core/mkp_scan.sv
rtl/core/mkp_ring.sv
rtl/core/matrix_keypad_scanner_with_key_buffer_core.sv
bench/matrix_keypad_scanner_with_key_buffer_core_test.sv
